// File: src/bb_pkg.sv
// Shared types and constants for the burst-balloons interval DP block.
// Depends on nothing; bb_ctrl, bb_datapath, the top level and the testbench import it.
`default_nettype none

package bb_pkg;

    localparam int unsigned DEF_MAX_BALLOONS = 64;
    localparam int unsigned VAL_W            = 8;
    localparam int unsigned COIN_W           = 31;

    localparam logic [COIN_W-1:0] SAT_LIMIT = '1;

    typedef struct packed {
        logic [VAL_W-1:0] balloon_value;
        logic             last_item;
    } t_in_item;

    typedef struct packed {
        logic [COIN_W-1:0] max_coins;
        logic              overflow;
    } t_out_item;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic val_we;
        logic set_start;
        logic edge_cap;
        logic left_one;
        logic right_one;
        logic issue;
        logic lo_empty;
        logic hi_empty;
        logic best_we;
        logic result_load;
    } t_bb_cmd;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_bb_sts;

endpackage

`default_nettype wire

// File: src/bb_ram.sv
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
`default_nettype none

module bb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// File: src/bb_datapath.sv
// Datapath: value and best-total memories, the candidate pipeline,
// the running maximum and the output register. Depends on bb_pkg, bb_ram.
`default_nettype none

module bb_datapath #(
    parameter int unsigned MAX_BALLOONS = bb_pkg::DEF_MAX_BALLOONS,
    localparam int unsigned IW = (MAX_BALLOONS > 1) ? $clog2(MAX_BALLOONS) : 1,
    localparam int unsigned BD = MAX_BALLOONS * MAX_BALLOONS,
    localparam int unsigned BW = (BD > 1) ? $clog2(BD) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire bb_pkg::t_bb_cmd           i_cmd,
    output bb_pkg::t_bb_sts                o_sts,
    input  wire logic [bb_pkg::VAL_W-1:0]  i_val_wdata,
    input  wire logic [IW-1:0]             i_val_waddr,
    input  wire logic [IW-1:0]             i_val_raddr_a,
    input  wire logic [IW-1:0]             i_val_raddr_b,
    input  wire logic [BW-1:0]             i_best_raddr_a,
    input  wire logic [BW-1:0]             i_best_raddr_b,
    input  wire logic [BW-1:0]             i_best_waddr,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output bb_pkg::t_out_item              o_out_item
);
    import bb_pkg::*;

    localparam int unsigned P1_W   = 2 * VAL_W;
    localparam int unsigned P2_W   = 3 * VAL_W;
    localparam int unsigned SUB_W  = COIN_W + 1;
    localparam int unsigned CAND_W = COIN_W + 2;

    logic [VAL_W-1:0]  w_val_a, w_val_b;
    logic [COIN_W-1:0] w_best_a, w_best_b;

    logic [VAL_W-1:0]  r_left, r_right;
    logic              r_s0_v, r_s0_lo_empty, r_s0_hi_empty;
    logic              r_s1_v, r_s2_v;
    logic [P1_W-1:0]   r_prod1;
    logic [SUB_W-1:0]  r_sub;
    logic [CAND_W-1:0] r_cand;
    logic [COIN_W-1:0] r_best;
    logic              r_sat;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic [P2_W-1:0]   w_prod2;
    logic [SUB_W-1:0]  w_sub;
    logic              w_over;
    logic [COIN_W-1:0] w_clip;

    bb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_BALLOONS)) u_val_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.val_we),
        .i_waddr   (i_val_waddr),
        .i_wdata   (i_val_wdata),
        .i_raddr_a (i_val_raddr_a),
        .i_raddr_b (i_val_raddr_b),
        .o_rdata_a (w_val_a),
        .o_rdata_b (w_val_b)
    );

    bb_ram #(.WIDTH(COIN_W), .DEPTH(BD)) u_best_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.best_we),
        .i_waddr   (i_best_waddr),
        .i_wdata   (r_best),
        .i_raddr_a (i_best_raddr_a),
        .i_raddr_b (i_best_raddr_b),
        .o_rdata_a (w_best_a),
        .o_rdata_b (w_best_b)
    );

    // Empty sub-intervals contribute nothing.
    assign w_sub = (r_s0_lo_empty ? SUB_W'(0) : SUB_W'(w_best_a))
                 + (r_s0_hi_empty ? SUB_W'(0) : SUB_W'(w_best_b));
    assign w_prod2 = r_prod1 * r_right;
    assign w_over  = r_cand > CAND_W'(SAT_LIMIT);
    assign w_clip  = w_over ? SAT_LIMIT : r_cand[COIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v      <= 1'b0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s0_v <= i_cmd.issue;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
            if (i_cmd.result_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_lo_empty <= i_cmd.lo_empty;
        r_s0_hi_empty <= i_cmd.hi_empty;
        r_prod1       <= r_left * w_val_a;
        r_sub         <= w_sub;
        r_cand        <= CAND_W'(w_prod2) + CAND_W'(r_sub);

        if (i_cmd.edge_cap) begin
            r_left  <= i_cmd.left_one  ? VAL_W'(1) : w_val_a;
            r_right <= i_cmd.right_one ? VAL_W'(1) : w_val_b;
        end

        if (i_cmd.edge_cap) begin
            r_best <= '0;
        end else if (r_s2_v && (w_clip > r_best)) begin
            r_best <= w_clip;
        end

        if (i_cmd.set_start) begin
            r_sat <= 1'b0;
        end else if (r_s2_v && w_over) begin
            r_sat <= 1'b1;
        end

        if (i_cmd.result_load) begin
            r_out_item.max_coins <= r_best;
            r_out_item.overflow  <= r_sat;
        end
    end

    assign o_sts.pipe_busy = r_s0_v | r_s1_v | r_s2_v;
    assign o_sts.out_free  = ~r_out_valid | i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;

endmodule

`default_nettype wire

// File: src/bb_ctrl.sv
// Sequencer: loads the set, then walks interval lengths, start points and
// split points, driving the datapath. Depends on bb_pkg.
`default_nettype none

module bb_ctrl #(
    parameter int unsigned MAX_BALLOONS = bb_pkg::DEF_MAX_BALLOONS,
    localparam int unsigned IW = (MAX_BALLOONS > 1) ? $clog2(MAX_BALLOONS) : 1,
    localparam int unsigned CW = $clog2(MAX_BALLOONS + 1),
    localparam int unsigned BD = MAX_BALLOONS * MAX_BALLOONS,
    localparam int unsigned BW = (BD > 1) ? $clog2(BD) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_last_item,
    output bb_pkg::t_bb_cmd      o_cmd,
    input  wire bb_pkg::t_bb_sts i_sts,
    output logic [IW-1:0]        o_val_waddr,
    output logic [IW-1:0]        o_val_raddr_a,
    output logic [IW-1:0]        o_val_raddr_b,
    output logic [BW-1:0]        o_best_raddr_a,
    output logic [BW-1:0]        o_best_raddr_b,
    output logic [BW-1:0]        o_best_waddr
);
    import bb_pkg::*;

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_HEAD  = 6'b000010,
        S_EDGE  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_WRITE = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_k, n_k;

    logic [CW-1:0] w_j, w_j1;
    logic          w_accept, w_room, w_final;

    assign w_j1     = r_i + r_len;
    assign w_j      = w_j1 - CW'(1);
    assign w_accept = i_in_valid && o_in_ready;
    assign w_room   = r_count < CW'(MAX_BALLOONS);
    assign w_final  = r_len == r_n;

    assign o_in_ready    = r_state == S_LOAD;
    assign o_val_waddr   = IW'(r_count);
    assign o_val_raddr_a = (r_state == S_HEAD) ? IW'(r_i - CW'(1)) : IW'(r_k);
    assign o_val_raddr_b = IW'(w_j1);
    // Row-major table: entry [lo][hi] sits at lo * MAX_BALLOONS + hi.
    assign o_best_raddr_a = BW'(r_i * MAX_BALLOONS + r_k - 1);
    assign o_best_raddr_b = BW'((r_k + 1) * MAX_BALLOONS + w_j);
    assign o_best_waddr   = BW'(r_i * MAX_BALLOONS + w_j);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_n     = r_n;
        n_len   = r_len;
        n_i     = r_i;
        n_k     = r_k;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    o_cmd.val_we = w_room;
                    n_count = w_room ? r_count + CW'(1) : r_count;
                    if (i_last_item) begin
                        o_cmd.set_start = 1'b1;
                        n_n     = n_count;
                        n_count = '0;
                        n_len   = CW'(1);
                        n_i     = '0;
                        n_state = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                n_state = S_EDGE;
            end
            S_EDGE: begin
                o_cmd.edge_cap  = 1'b1;
                o_cmd.left_one  = r_i == '0;
                o_cmd.right_one = w_j1 >= r_n;
                n_k     = r_i;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.issue    = 1'b1;
                o_cmd.lo_empty = r_k == r_i;
                o_cmd.hi_empty = r_k == w_j;
                if (r_k == w_j) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.best_we = 1'b1;
                if (w_final) begin
                    if (i_sts.out_free) begin
                        o_cmd.result_load = 1'b1;
                        n_state = S_LOAD;
                    end
                end else begin
                    if (w_j1 == r_n) begin
                        n_len = r_len + CW'(1);
                        n_i   = '0;
                    end else begin
                        n_i = r_i + CW'(1);
                    end
                    n_state = S_HEAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_len <= n_len;
        r_i   <= n_i;
        r_k   <= n_k;
    end

endmodule

`default_nettype wire

// File: src/interval_dp_burst_balloons_core.sv
// Loading: one item per cycle while the loader is open; after the closing item the table is
// filled, interval by interval and split point by split point, through the single candidate pipeline.
// Throughput: one set at a time; the next set loads while the previous result waits.
// Reset: synchronous, active low; clears the sequencer, the load count and all valid flags.
// Top level of the burst-balloons interval DP block. Depends on bb_pkg, bb_ctrl,
// bb_datapath, bb_ram.
`default_nettype none

module interval_dp_burst_balloons_core #(
    parameter int unsigned MAX_BALLOONS = bb_pkg::DEF_MAX_BALLOONS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire bb_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output bb_pkg::t_out_item      o_out_item
);
    import bb_pkg::*;

    localparam int unsigned IW = (MAX_BALLOONS > 1) ? $clog2(MAX_BALLOONS) : 1;
    localparam int unsigned BD = MAX_BALLOONS * MAX_BALLOONS;
    localparam int unsigned BW = (BD > 1) ? $clog2(BD) : 1;

    // The sequencer owns every loop counter and all addressing; the datapath
    // owns the memories, the arithmetic and the result register.
    t_bb_cmd       w_cmd;
    t_bb_sts       w_sts;
    logic [IW-1:0] w_val_waddr, w_val_raddr_a, w_val_raddr_b;
    logic [BW-1:0] w_best_raddr_a, w_best_raddr_b, w_best_waddr;

    bb_ctrl #(.MAX_BALLOONS(MAX_BALLOONS)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_last_item    (i_in_item.last_item),
        .o_cmd          (w_cmd),
        .i_sts          (w_sts),
        .o_val_waddr    (w_val_waddr),
        .o_val_raddr_a  (w_val_raddr_a),
        .o_val_raddr_b  (w_val_raddr_b),
        .o_best_raddr_a (w_best_raddr_a),
        .o_best_raddr_b (w_best_raddr_b),
        .o_best_waddr   (w_best_waddr)
    );

    // Each split point enters a four-stage pipeline: memory read, left times
    // value plus sub-interval sums, times right, then clamp and running maximum.
    bb_datapath #(.MAX_BALLOONS(MAX_BALLOONS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_val_wdata    (i_in_item.balloon_value),
        .i_val_waddr    (w_val_waddr),
        .i_val_raddr_a  (w_val_raddr_a),
        .i_val_raddr_b  (w_val_raddr_b),
        .i_best_raddr_a (w_best_raddr_a),
        .i_best_raddr_b (w_best_raddr_b),
        .i_best_waddr   (w_best_waddr),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_out_item     (o_out_item)
    );

    // A table entry is only written once every split point has left the pipeline.
    a_write_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.best_we |-> !w_sts.pipe_busy)
        else $error("best total written while candidates are in flight");

    // The item that closes a set starts the fill, so loading stops right after it.
    a_stop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.last_item) |=> !o_in_ready)
        else $error("loader still open after the closing item");

    // A saturated sub-interval propagates upward, so the whole set saturates too.
    a_overflow_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.overflow) |-> (o_out_item.max_coins == SAT_LIMIT))
        else $error("overflow flagged without a saturated total");

    // A new result only appears when the sequencer loads one.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.result_load))
        else $error("result appeared without a load command");

endmodule

`default_nettype wire

// File: tb/interval_dp_burst_balloons_core_tb.sv
// Self-checking testbench for interval_dp_burst_balloons_core: balloon sets go in, best coin totals
// come out and are compared against an in-bench interval DP predictor. Depends on bb_pkg and
// on the block under test.
`default_nettype none

module interval_dp_burst_balloons_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bb_pkg::*;

    localparam int unsigned BALLOON_CAP = DEF_MAX_BALLOONS;
    // The random part stops opening new sets once this many balloons have gone in.
    localparam int unsigned ITEM_TARGET = 580;
    // Idling stops for at least this many items at the end of the run.
    localparam int unsigned CALM_TAIL   = 60;
    // The two full sets of 64, the small ones and the worst sender gaps and receiver stalls
    // stay well under this limit.
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned DRAIN_WAIT  = 64;
    localparam int unsigned SHOW_LIMIT  = 10;
    localparam int unsigned SCRIPT_LEN  = 22;

    // One row of the directed script. Where known is set, the expected total is the one
    // typed in the row instead of the predicted one.
    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic              last;
        logic              known;
        logic [COIN_W-1:0] coins;
    } t_script_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  in_item = '0;
    logic      o_out_valid;
    logic      out_ready = 1'b0;
    t_out_item o_out_item;

    // Predictor state: the loaded balloons, how many are held, and the per-interval totals.
    logic [VAL_W-1:0] balloons [BALLOON_CAP];
    int unsigned      balloon_count = 0;
    logic [31:0]      interval_best [BALLOON_CAP][BALLOON_CAP];

    // Totals that are owed by the block, oldest first.
    t_out_item   coins_due [$];
    t_out_item   want;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    bit          idle_on = 1'b1;
    t_script_row script [SCRIPT_LEN];

    always #6 i_clk = ~i_clk;

    interval_dp_burst_balloons_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    // Fills the interval table bottom-up, shortest intervals first. For every interval the
    // balloon burst last is tried at each position: its gain uses the outer neighbours of the
    // interval (a value of one past either end of the set), and the best totals of the two
    // sides, which are shorter and therefore already in the table. Every candidate above the
    // 31-bit ceiling is clamped and flags the result.
    function automatic t_out_item best_coin_total(input int unsigned n);
        longint unsigned left_v;
        longint unsigned right_v;
        longint unsigned cand;
        longint unsigned best;
        int unsigned     span;
        int unsigned     i;
        int unsigned     j;
        int unsigned     k;
        logic            clamped;
        t_out_item       res;
        clamped = 1'b0;
        for (span = 1; span <= n; span++) begin
            for (i = 0; i + span <= n; i++) begin
                j       = i + span - 1;
                left_v  = (i == 0) ? 64'd1 : 64'(balloons[i-1]);
                right_v = (j + 1 >= n) ? 64'd1 : 64'(balloons[j+1]);
                best    = 0;
                for (k = i; k <= j; k++) begin
                    cand = left_v * 64'(balloons[k]) * right_v;
                    if (k > i) begin
                        cand += 64'(interval_best[i][k-1]);
                    end
                    if (k < j) begin
                        cand += 64'(interval_best[k+1][j]);
                    end
                    if (cand > 64'(SAT_LIMIT)) begin
                        cand    = 64'(SAT_LIMIT);
                        clamped = 1'b1;
                    end
                    if (cand > best) begin
                        best = cand;
                    end
                end
                interval_best[i][j] = best[31:0];
            end
        end
        res.max_coins = interval_best[0][n-1][COIN_W-1:0];
        res.overflow  = clamped;
        return res;
    endfunction

    // Loads one balloon into the predictor. Values beyond the store's capacity are dropped,
    // but a closing item still ends the set and yields the total of what was kept.
    task automatic load_balloon(input t_in_item it, output bit closed, output t_out_item res);
        closed = 1'b0;
        res    = '0;
        if (balloon_count < BALLOON_CAP) begin
            balloons[balloon_count] = it.balloon_value;
            balloon_count++;
        end
        if (it.last_item) begin
            res           = best_coin_total(balloon_count);
            closed        = 1'b1;
            balloon_count = 0;
        end
    endtask

    // Presents one balloon and holds it until the block takes it. A random idle burst may come
    // first; valid is only lowered for such a burst, so back-to-back items keep it high.
    // On acceptance the predictor advances and any owed total is queued.
    task automatic offer_balloon(input t_in_item it, input bit known,
                                 input logic [COIN_W-1:0] coins);
        int unsigned gap;
        bit          closed;
        t_out_item   res;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        load_balloon(it, closed, res);
        if (closed) begin
            if (known) begin
                res.max_coins = coins;
                res.overflow  = 1'b0;
            end
            coins_due = {coins_due, res};
        end
    endtask

    // The receiver stalls in random bursts while idling is on and checks every accepted total
    // against the oldest one owed. Inputs and outputs are sampled before this edge's updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (coins_due.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOW_LIMIT) begin
                    $display("unexpected total: max_coins %0d overflow %0d",
                             o_out_item.max_coins, o_out_item.overflow);
                end
            end else begin
                want = coins_due.pop_front();
                if (o_out_item.max_coins !== want.max_coins ||
                        o_out_item.overflow !== want.overflow) begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT) begin
                        $display("total mismatch: max_coins exp %0d got %0d, %s %0d got %0d",
                                 want.max_coins, o_out_item.max_coins, "overflow exp",
                                 want.overflow, o_out_item.overflow);
                    end
                end
            end
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 16);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // A hung block ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_in_item    it;
        int unsigned sent;
        int unsigned set_no;
        int unsigned span;
        int unsigned flavor;
        int unsigned p;
        int unsigned r;
        sent   = 0;
        set_no = 0;

        // Directed sets: single balloons at both extremes, the classic four-balloon example,
        // a pair of maximum values, an all-zero set and a few mixed extremes.
        script = '{
            '{8'd0,   1'b1, 1'b1, 31'd0},
            '{8'd255, 1'b1, 1'b1, 31'd255},
            '{8'd1,   1'b1, 1'b1, 31'd1},
            '{8'd3,   1'b0, 1'b0, 31'd0},
            '{8'd1,   1'b0, 1'b0, 31'd0},
            '{8'd5,   1'b0, 1'b0, 31'd0},
            '{8'd8,   1'b1, 1'b1, 31'd167},
            '{8'd255, 1'b0, 1'b0, 31'd0},
            '{8'd255, 1'b1, 1'b1, 31'd65280},
            '{8'd0,   1'b0, 1'b0, 31'd0},
            '{8'd0,   1'b0, 1'b0, 31'd0},
            '{8'd0,   1'b1, 1'b1, 31'd0},
            '{8'd128, 1'b0, 1'b0, 31'd0},
            '{8'd64,  1'b0, 1'b0, 31'd0},
            '{8'd1,   1'b1, 1'b0, 31'd0},
            '{8'd255, 1'b0, 1'b0, 31'd0},
            '{8'd0,   1'b0, 1'b0, 31'd0},
            '{8'd255, 1'b0, 1'b0, 31'd0},
            '{8'd0,   1'b1, 1'b0, 31'd0},
            '{8'd255, 1'b0, 1'b0, 31'd0},
            '{8'd255, 1'b0, 1'b0, 31'd0},
            '{8'd255, 1'b1, 1'b0, 31'd0}
        };

        // Synchronous reset, held and then released.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (p = 0; p < SCRIPT_LEN; p++) begin
            it.balloon_value = script[p].value;
            it.last_item     = script[p].last;
            offer_balloon(it, script[p].known, script[p].coins);
        end

        // Hold the sender off until every directed total has come back.
        in_valid <= 1'b0;
        while (coins_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);

        // Random sets. Most are short so that the cubic fill stays cheap; one fills the store
        // exactly with maximum values, and one runs past capacity so that the extra balloons,
        // the closing one among them, are dropped.
        while (sent < ITEM_TARGET) begin
            set_no++;
            if (set_no == 9) begin
                span   = BALLOON_CAP;
                flavor = 0;
            end else begin
                if (set_no == 30) begin
                    span = BALLOON_CAP + $urandom_range(1, 8);
                end else if ($urandom_range(0, 4) == 0) begin
                    span = $urandom_range(11, 24);
                end else begin
                    span = $urandom_range(1, 10);
                end
                flavor = $urandom_range(0, 7);
            end
            for (p = 0; p < span; p++) begin
                case (flavor)
                    0: it.balloon_value = 8'd255;
                    1: it.balloon_value = 8'd0;
                    2: it.balloon_value = p[0] ? 8'd0 : 8'd255;
                    default: begin
                        r = $urandom_range(0, 9);
                        if (r == 0) begin
                            it.balloon_value = 8'd0;
                        end else if (r == 1) begin
                            it.balloon_value = 8'd255;
                        end else begin
                            it.balloon_value = VAL_W'($urandom_range(0, 255));
                        end
                    end
                endcase
                it.last_item = (p == span - 1);
                if (sent + CALM_TAIL >= ITEM_TARGET) begin
                    idle_on = 1'b0;
                end
                offer_balloon(it, 1'b0, '0);
                sent++;
            end
        end
        in_valid <= 1'b0;

        // Drain: every owed total must arrive, then a short quiet spell catches stray results.
        while (coins_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
